// ----- rtl/mrlb_pkg.sv -----
// Shared types and constants of the minimum-raggedness line breaker.
`timescale 1ns / 1ps
package mrlb_pkg;

  localparam int WORD_W    = 12;
  localparam int GAP_W     = 10;
  localparam int PAGE_W    = 12;
  localparam int INDENT_W  = 11;
  localparam int EFF_W     = 14;
  localparam int LEN_W     = 17;
  localparam int REM_W     = 16;
  localparam int COST_W    = 31;
  localparam int BRK_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDENT = 2'd1;

  localparam logic [PAGE_W-1:0] PAGE_WIDTH_RESET = 12'd480;

  typedef logic [COST_W-1:0] cost_t;

  localparam cost_t COST_MAX = '1;

  typedef enum logic [2:0] {
    CU_HOLD,
    CU_ROW,
    CU_ACC,
    CU_MUL,
    CU_ADD,
    CU_ZERO
  } cu_op_t;

  typedef struct packed {
    cu_op_t                   op;
    logic                     first;
    logic signed [EFF_W-1:0]  eff;
  } cu_ctl_t;

  typedef struct packed {
    logic over;
    logic better;
    logic none;
  } cu_status_t;

endpackage

// ----- rtl/min_raggedness_line_breaker_core.sv -----
// Top level of the minimum-raggedness line breaker: load, solve and emit sequencer.
`timescale 1ns / 1ps
//
// Channel  Handshake                  Payload
// cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
// word     word_valid / word_stall    word_width, gap_before, attach_to_previous, last_word
// break    break_valid / break_stall  break_index, last_line
//
// Words load one per cycle while the block is idle.
// The solve has an init step, then per start word a row and a finish step; each scanned word
// is read and accumulated, then squared and added at a legal break, or zeroed at the last.
// Each line then takes a table read, an output load and its request, held by any break_stall.
// Reset sets page_width to 480 and first_line_indent to 0 and clears the word count.
// word_stall stays high from the paragraph's last word until its last break is taken.
module min_raggedness_line_breaker_core #(
  parameter int MAX_WORDS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mrlb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrlb_pkg::PAGE_W-1:0]          cfg_data,
  input  logic                                 word_valid,
  output logic                                 word_stall,
  input  logic [mrlb_pkg::WORD_W-1:0]          word_width,
  input  logic signed [mrlb_pkg::GAP_W-1:0]    gap_before,
  input  logic                                 attach_to_previous,
  input  logic                                 last_word,
  output logic                                 break_valid,
  input  logic                                 break_stall,
  output logic [mrlb_pkg::BRK_W-1:0]           break_index,
  output logic                                 last_line
);
  import mrlb_pkg::*;

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_ROW  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ADD  = 4'd6;
  localparam logic [3:0] S_ZERO = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_ERD  = 4'd9;
  localparam logic [3:0] S_ELD  = 4'd10;
  localparam logic [3:0] S_EOUT = 4'd11;

  logic [3:0]                 state;
  logic [PAGE_W-1:0]          page_width;
  logic [INDENT_W-1:0]        first_line_indent;
  logic [CW-1:0]              word_count;
  logic [CW-1:0]              count_inc;
  logic [CW-1:0]              j_inc;
  logic [AW-1:0]              i;
  logic [AW-1:0]              j;
  logic [AW-1:0]              cur;
  logic [AW-1:0]              best_end;
  cost_t                      prev_best;
  logic                       word_acc;
  logic                       para_end;
  logic                       last_j;
  logic signed [EFF_W-1:0]    eff;
  logic signed [EFF_W-1:0]    indent_x;

  logic [WORD_W-1:0]          rd_width;
  logic [GAP_W-1:0]           rd_gap;
  logic                       rd_attach;
  cost_t                      rd_cost;
  logic [AW-1:0]              rd_end;

  logic                       tbl_we;
  logic [AW-1:0]              tbl_waddr;
  cost_t                      tbl_cost;
  logic [AW-1:0]              tbl_end;

  cu_ctl_t                    cu_ctl;
  cu_status_t                 cu_status;
  cost_t                      cu_best;

  assign cfg_ready  = 1'b1;
  assign word_stall = state != S_IDLE;
  assign word_acc   = word_valid && !word_stall;
  assign count_inc  = word_count + CW'(1);
  assign para_end   = last_word || (count_inc == CW'(MAX_WORDS));
  assign j_inc      = CW'(j) + CW'(1);
  assign last_j     = j_inc == word_count;

  assign indent_x = {{(EFF_W-INDENT_W){first_line_indent[INDENT_W-1]}}, first_line_indent};
  assign eff      = $signed({{(EFF_W-PAGE_W){1'b0}}, page_width})
                    - ((i == '0) ? indent_x : '0);

  always_comb begin
    cu_ctl.first = j == i;
    cu_ctl.eff   = eff;
    unique case (state)
      S_ROW:   cu_ctl.op = CU_ROW;
      S_ACC:   cu_ctl.op = CU_ACC;
      S_MUL:   cu_ctl.op = CU_MUL;
      S_ADD:   cu_ctl.op = CU_ADD;
      S_ZERO:  cu_ctl.op = CU_ZERO;
      default: cu_ctl.op = CU_HOLD;
    endcase
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = i;
    tbl_cost  = cu_status.none ? prev_best : cu_best;
    tbl_end   = cu_status.none ? i : best_end;
    if (state == S_INIT) begin
      tbl_we    = 1'b1;
      tbl_waddr = AW'(word_count - CW'(1));
      tbl_cost  = '0;
      tbl_end   = AW'(word_count - CW'(1));
    end else if (state == S_FIN) begin
      tbl_we = 1'b1;
    end
  end

  mrlb_word_store #(
    .DEPTH(MAX_WORDS)
  ) u_word_store (
    .clk          (clk),
    .we           (word_acc),
    .waddr        (word_count[AW-1:0]),
    .wr_width     (word_width),
    .wr_gap       (gap_before),
    .wr_attach    (attach_to_previous),
    .word_raddr   (j),
    .attach_raddr (j_inc[AW-1:0]),
    .rd_width     (rd_width),
    .rd_gap       (rd_gap),
    .rd_attach    (rd_attach)
  );

  mrlb_dp_table #(
    .DEPTH(MAX_WORDS)
  ) u_dp_table (
    .clk        (clk),
    .we         (tbl_we),
    .waddr      (tbl_waddr),
    .wr_cost    (tbl_cost),
    .wr_end     (tbl_end),
    .cost_raddr (j_inc[AW-1:0]),
    .end_raddr  (cur),
    .rd_cost    (rd_cost),
    .rd_end     (rd_end)
  );

  mrlb_cost_unit u_cost_unit (
    .clk        (clk),
    .ctl        (cu_ctl),
    .word_width (rd_width),
    .gap        (rd_gap),
    .best_next  (rd_cost),
    .status     (cu_status),
    .best       (cu_best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      page_width        <= PAGE_WIDTH_RESET;
      first_line_indent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PAGE_WIDTH) begin
        page_width <= cfg_data;
      end else if (cfg_index == CFG_FIRST_INDENT) begin
        first_line_indent <= cfg_data[INDENT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      word_count  <= '0;
      break_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (word_acc) begin
            word_count <= count_inc;
            if (para_end) begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          prev_best <= '0;
          cur       <= '0;
          if (word_count == CW'(1)) begin
            state <= S_ERD;
          end else begin
            i     <= AW'(word_count - CW'(2));
            state <= S_ROW;
          end
        end
        S_ROW: begin
          j     <= i;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          priority if (cu_status.over) begin
            state <= S_FIN;
          end else if (!last_j && rd_attach) begin
            j     <= j + AW'(1);
            state <= S_RD;
          end else if (last_j) begin
            state <= S_ZERO;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (cu_status.better) begin
            best_end <= j;
          end
          j     <= j + AW'(1);
          state <= S_RD;
        end
        S_ZERO: begin
          if (cu_status.better) begin
            best_end <= j;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          prev_best <= tbl_cost;
          if (i == '0) begin
            cur   <= '0;
            state <= S_ERD;
          end else begin
            i     <= i - AW'(1);
            state <= S_ROW;
          end
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          break_index <= BRK_W'(rd_end) + BRK_W'(1);
          last_line   <= (CW'(rd_end) + CW'(1)) == word_count;
          break_valid <= 1'b1;
          state       <= S_EOUT;
        end
        S_EOUT: begin
          if (!break_stall) begin
            break_valid <= 1'b0;
            if (last_line) begin
              word_count <= '0;
              state      <= S_IDLE;
            end else begin
              cur   <= break_index[AW-1:0];
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_line_end_order: assert property (@(posedge clk) disable iff (rst)
    state == S_ELD |-> rd_end >= cur)
    else $error("line end lies before its start word");

  a_last_break_count: assert property (@(posedge clk) disable iff (rst)
    break_valid && last_line |-> break_index == BRK_W'(word_count))
    else $error("final break does not match the word count");

  a_para_solve: assert property (@(posedge clk) disable iff (rst)
    word_acc && last_word |=> state == S_INIT)
    else $error("last word did not start the solve");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    word_count <= CW'(MAX_WORDS))
    else $error("word count beyond store depth");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |-> j >= i && j_inc <= word_count)
    else $error("scan index outside the current row");
`endif

endmodule

// ----- rtl/mrlb_word_store.sv -----
// Word memories holding width, gap and attach flag of each stored word.
`timescale 1ns / 1ps
module mrlb_word_store #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [mrlb_pkg::WORD_W-1:0] wr_width,
  input  logic [mrlb_pkg::GAP_W-1:0]  wr_gap,
  input  logic                        wr_attach,
  input  logic [AW-1:0]               word_raddr,
  input  logic [AW-1:0]               attach_raddr,
  output logic [mrlb_pkg::WORD_W-1:0] rd_width,
  output logic [mrlb_pkg::GAP_W-1:0]  rd_gap,
  output logic                        rd_attach
);
  import mrlb_pkg::*;

  logic [WORD_W-1:0] width_mem [DEPTH];
  logic [GAP_W-1:0]  gap_mem [DEPTH];
  logic              attach_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      width_mem[waddr]  <= wr_width;
      gap_mem[waddr]    <= wr_gap;
      attach_mem[waddr] <= wr_attach;
    end
    rd_width  <= width_mem[word_raddr];
    rd_gap    <= gap_mem[word_raddr];
    rd_attach <= attach_mem[attach_raddr];
  end

endmodule

// ----- rtl/mrlb_dp_table.sv -----
// Dynamic-program tables: best cost and best line end for each start word.
`timescale 1ns / 1ps
module mrlb_dp_table #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mrlb_pkg::cost_t wr_cost,
  input  logic [AW-1:0]   wr_end,
  input  logic [AW-1:0]   cost_raddr,
  input  logic [AW-1:0]   end_raddr,
  output mrlb_pkg::cost_t rd_cost,
  output logic [AW-1:0]   rd_end
);
  import mrlb_pkg::*;

  cost_t         cost_mem [DEPTH];
  logic [AW-1:0] end_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cost_mem[waddr] <= wr_cost;
      end_mem[waddr]  <= wr_end;
    end
    rd_cost <= cost_mem[cost_raddr];
    rd_end  <= end_mem[end_raddr];
  end

endmodule

// ----- rtl/mrlb_cost_unit.sv -----
// Shared line-cost unit: length accumulate, fit compare, square, add and minimum.
`timescale 1ns / 1ps
module mrlb_cost_unit (
  input  logic                              clk,
  input  mrlb_pkg::cu_ctl_t                 ctl,
  input  logic [mrlb_pkg::WORD_W-1:0]       word_width,
  input  logic [mrlb_pkg::GAP_W-1:0]        gap,
  input  mrlb_pkg::cost_t                   best_next,
  output mrlb_pkg::cu_status_t              status,
  output mrlb_pkg::cost_t                   best
);
  import mrlb_pkg::*;

  logic signed [LEN_W-1:0] len;
  logic signed [LEN_W-1:0] len_next;
  logic signed [LEN_W-1:0] eff_x;
  logic signed [LEN_W-1:0] gap_x;
  logic signed [LEN_W-1:0] width_x;
  logic signed [LEN_W-1:0] rem_full;
  logic [REM_W-1:0]        rem;
  logic [2*REM_W-1:0]      prod;
  logic [COST_W:0]         sum;
  cost_t                   sq;
  cost_t                   cand;

  assign gap_x    = ctl.first ? '0 : {{(LEN_W-GAP_W){gap[GAP_W-1]}}, gap};
  assign width_x  = {{(LEN_W-WORD_W){1'b0}}, word_width};
  assign eff_x    = {{(LEN_W-EFF_W){ctl.eff[EFF_W-1]}}, ctl.eff};
  assign len_next = len + width_x + gap_x;
  assign rem_full = eff_x - len_next;
  assign prod     = rem * rem;
  assign sum      = {1'b0, sq} + {1'b0, best_next};
  assign cand     = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];

  always_comb begin
    status.over = len_next > eff_x;
    status.none = best == COST_MAX;
    unique case (ctl.op)
      CU_ADD:  status.better = cand < best;
      CU_ZERO: status.better = best != '0;
      default: status.better = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CU_ROW: begin
        len  <= '0;
        best <= COST_MAX;
      end
      CU_ACC: begin
        len <= len_next;
        rem <= rem_full[REM_W-1:0];
      end
      CU_MUL: begin
        sq <= prod[COST_W-1:0];
      end
      CU_ADD: begin
        if (status.better) begin
          best <= cand;
        end
      end
      CU_ZERO: begin
        best <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- dv/tb_min_raggedness_line_breaker_core.sv -----
// Self-checking testbench for the minimum-raggedness line breaker core.
`timescale 1ns / 1ps
module tb_min_raggedness_line_breaker_core;
  import mrlb_pkg::*;

  localparam int MAX_WORDS = 64;
  localparam int RANDOM_WORDS = 450;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam longint COST_CAP = longint'(COST_MAX);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [PAGE_W-1:0]       reg_val;
    logic [WORD_W-1:0]       width;
    logic signed [GAP_W-1:0] gap;
    logic                    attach;
    logic                    last;
    logic [1:0]              lines;
    logic [BRK_W-1:0]        brk0;
    logic [BRK_W-1:0]        brk1;
  } row_t;

  typedef struct packed {
    logic [BRK_W-1:0] idx;
    logic             last;
  } line_break_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAGE_W-1:0] cfg_data = '0;
  logic word_valid = 1'b0;
  logic word_stall;
  logic [WORD_W-1:0] word_width = '0;
  logic signed [GAP_W-1:0] gap_before = '0;
  logic attach_to_previous = 1'b0;
  logic last_word = 1'b0;
  logic break_valid;
  logic break_stall = 1'b0;
  logic [BRK_W-1:0] break_index;
  logic last_line;

  logic [WORD_W-1:0] para_width [MAX_WORDS];
  logic signed [GAP_W-1:0] para_gap [MAX_WORDS];
  logic para_attach [MAX_WORDS];
  int para_len = 0;
  logic [PAGE_W-1:0] cur_page = PAGE_WIDTH_RESET;
  logic signed [INDENT_W-1:0] cur_indent = '0;

  line_break_t break_q [$];
  line_break_t due;
  int errors = 0;
  bit calm = 1'b0;
  int stall_run = 0;
  int stall_pick;
  int unsigned cycle_count = 0;
  int random_words = 0;
  row_t script [31];

  min_raggedness_line_breaker_core #(.MAX_WORDS(MAX_WORDS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .word_valid(word_valid),
    .word_stall(word_stall),
    .word_width(word_width),
    .gap_before(gap_before),
    .attach_to_previous(attach_to_previous),
    .last_word(last_word),
    .break_valid(break_valid),
    .break_stall(break_stall),
    .break_index(break_index),
    .last_line(last_line)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      break_stall <= 1'b1;
    end else if (calm) begin
      break_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 65) begin
        break_stall <= 1'b0;
      end else if (stall_pick < 95) begin
        break_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        break_stall <= 1'b1;
        stall_run <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && break_valid && !break_stall) begin
      if (break_q.size() == 0) begin
        $error("unexpected break request: break_index %0d, last_line %0d",
               break_index, last_line);
        errors++;
      end else begin
        due = break_q.pop_front();
        if (break_index !== due.idx) begin
          $error("break_index: expected %0d, actual %0d", due.idx, break_index);
          errors++;
        end
        if (last_line !== due.last) begin
          $error("last_line: expected %0d, actual %0d", due.last, last_line);
          errors++;
        end
      end
    end
  end

  function automatic row_t wrow(input logic [WORD_W-1:0] w, input logic signed [GAP_W-1:0] g,
                                input logic a, input logic l, input logic [1:0] lines,
                                input logic [BRK_W-1:0] b0, input logic [BRK_W-1:0] b1);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.width = w;
    r.gap = g;
    r.attach = a;
    r.last = l;
    r.lines = lines;
    r.brk0 = b0;
    r.brk1 = b1;
    return r;
  endfunction

  function automatic row_t crow(input logic [CFG_IDX_W-1:0] idx, input logic [PAGE_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic int idle_gap();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic enqueue_break(input line_break_t lb);
    break_q = {break_q, lb};
  endtask

  // Backward pass: cheapest lines from each start word; then queues the breaks.
  task automatic plan_paragraph(input int n, output int made);
    longint tail_cost [MAX_WORDS];
    int line_end [MAX_WORDS];
    longint run, avail, c, rest;
    int cur, nxt;
    line_break_t lb;
    tail_cost[n-1] = 0;
    line_end[n-1] = n - 1;
    for (int i = n - 2; i >= 0; i--) begin
      run = 0;
      avail = longint'(cur_page) - ((i == 0) ? longint'(cur_indent) : 64'sd0);
      tail_cost[i] = COST_CAP;
      line_end[i] = i;
      for (int j = i; j < n; j++) begin
        run = run + longint'(para_width[j]) + ((j > i) ? longint'(para_gap[j]) : 64'sd0);
        if (run > avail) break;
        if (j + 1 < n && para_attach[j+1]) continue;
        if (j == n - 1) begin
          c = 0;
        end else begin
          rest = avail - run;
          c = rest * rest + tail_cost[j+1];
          if (c > COST_CAP) c = COST_CAP;
        end
        if (c < tail_cost[i]) begin
          tail_cost[i] = c;
          line_end[i] = j;
        end
      end
      if (tail_cost[i] == COST_CAP) begin
        line_end[i] = i;
        tail_cost[i] = tail_cost[i+1];
      end
    end
    made = 0;
    cur = 0;
    while (cur < n) begin
      nxt = line_end[cur] + 1;
      if (nxt <= cur) nxt = cur + 1;
      if (nxt > n) nxt = n;
      lb.idx = nxt[BRK_W-1:0];
      lb.last = (nxt >= n);
      enqueue_break(lb);
      made++;
      cur = nxt;
    end
  endtask

  task automatic absorb_word(input row_t r, output int made);
    made = 0;
    if (para_len >= MAX_WORDS) para_len = 0;
    para_width[para_len] = r.width;
    para_gap[para_len] = r.gap;
    para_attach[para_len] = r.attach;
    para_len++;
    if (!r.last && para_len < MAX_WORDS) return;
    plan_paragraph(para_len, made);
    para_len = 0;
  endtask

  task automatic push_word(input row_t r);
    int made, pause;
    line_break_t lb;
    word_valid <= 1'b1;
    word_width <= r.width;
    gap_before <= r.gap;
    attach_to_previous <= r.attach;
    last_word <= r.last;
    @(posedge clk);
    while (word_stall) @(posedge clk);
    absorb_word(r, made);
    if (made > 0 && r.lines != 0) begin
      repeat (made) break_q.delete(break_q.size() - 1);
      lb.idx = r.brk0;
      lb.last = (r.lines == 1);
      enqueue_break(lb);
      if (r.lines == 2) begin
        lb.idx = r.brk1;
        lb.last = 1'b1;
        enqueue_break(lb);
      end
    end
    pause = idle_gap();
    if (pause > 0) begin
      word_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAGE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PAGE_WIDTH: cur_page = val;
      CFG_FIRST_INDENT: cur_indent = val[INDENT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    word_valid <= 1'b0;
    while (break_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_setup();
    int mode;
    logic [PAGE_W-1:0] page;
    logic signed [INDENT_W-1:0] ind;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      page = PAGE_W'($urandom_range(160, 900));
      ind = INDENT_W'($urandom_range(0, 180) - 60);
    end else if (mode < 8) begin
      page = PAGE_W'($urandom_range(0, 4095));
      ind = INDENT_W'($urandom_range(0, 2047));
    end else begin
      case ($urandom_range(0, 2))
        0: page = 12'd0;
        1: page = 12'd1;
        default: page = 12'd4095;
      endcase
      ind = $urandom_range(0, 1) ? -11'sd1024 : 11'sd1023;
    end
    settle();
    case ($urandom_range(0, 3))
      0: set_reg(CFG_PAGE_WIDTH, page);
      1: set_reg(CFG_FIRST_INDENT, {1'($urandom), ind});
      2: begin
        set_reg(CFG_FIRST_INDENT, {1'($urandom), ind});
        set_reg(CFG_PAGE_WIDTH, page);
      end
      default: begin
        set_reg(CFG_PAGE_WIDTH, page);
        set_reg(CFG_FIRST_INDENT, {1'($urandom), ind});
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic random_paragraph(input bit overlong);
    int count, pick, span;
    bit no_last;
    row_t item;
    pick = $urandom_range(0, 19);
    if (overlong || pick == 0) count = MAX_WORDS;
    else if (pick < 4) count = $urandom_range(13, 40);
    else count = $urandom_range(1, 12);
    no_last = overlong || (count == MAX_WORDS && $urandom_range(0, 1) == 1);
    span = int'(cur_page) / 5 + 4;
    for (int k = 0; k < count; k++) begin
      item = '0;
      item.kind = ROW_WORD;
      item.width = ($urandom_range(0, 11) == 0) ? WORD_W'($urandom_range(0, 4095))
                                                : WORD_W'($urandom_range(0, span));
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        item.gap = GAP_W'($urandom_range(0, 1023));
        item.attach = 1'($urandom_range(0, 1));
      end else if (pick < 3) begin
        item.gap = GAP_W'($urandom_range(0, 12) - 8);
        item.attach = 1'b1;
      end else begin
        item.gap = GAP_W'($urandom_range(2, 16));
        item.attach = 1'b0;
      end
      item.last = (k == count - 1) && !no_last;
      push_word(item);
      random_words++;
    end
  endtask

  initial begin
    script = '{
      wrow(12'd100, 10'sd0, 1'b0, 1'b1, 2'd1, 7'd1, 7'd0),
      wrow(12'd4095, 10'sd511, 1'b1, 1'b1, 2'd1, 7'd1, 7'd0),
      wrow(12'd4095, 10'sd0, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd4095, -10'sd512, 1'b0, 1'b1, 2'd2, 7'd1, 7'd2),
      wrow(12'd100, 10'sd0, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd100, 10'sd10, 1'b1, 1'b1, 2'd1, 7'd2, 7'd0),
      wrow(12'd200, 10'sd0, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd150, 10'sd12, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd180, 10'sd12, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd90, 10'sd12, 1'b1, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd60, 10'sd12, 1'b0, 1'b1, 2'd0, 7'd0, 7'd0),
      crow(CFG_PAGE_WIDTH, 12'd0),
      wrow(12'd5, 10'sd0, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd5, 10'sd3, 1'b0, 1'b1, 2'd2, 7'd1, 7'd2),
      crow(CFG_PAGE_WIDTH, 12'd4095),
      crow(CFG_FIRST_INDENT, 12'hC00),
      wrow(12'd4095, 10'sd0, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd1000, 10'sd20, 1'b0, 1'b1, 2'd1, 7'd2, 7'd0),
      crow(CFG_PAGE_WIDTH, 12'd100),
      crow(CFG_FIRST_INDENT, 12'h3FF),
      wrow(12'd10, 10'sd0, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd10, 10'sd5, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd10, 10'sd5, 1'b0, 1'b1, 2'd2, 7'd1, 7'd3),
      crow(CFG_PAGE_WIDTH, 12'd1),
      crow(CFG_FIRST_INDENT, 12'd0),
      wrow(12'd1, 10'sd0, 1'b0, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd0, -10'sd512, 1'b1, 1'b0, 2'd0, 7'd0, 7'd0),
      wrow(12'd1, 10'sd0, 1'b0, 1'b1, 2'd0, 7'd0, 7'd0),
      crow(CFG_SPARE, 12'hFFF),
      crow(CFG_PAGE_WIDTH, PAGE_WIDTH_RESET),
      wrow(12'd0, 10'sd0, 1'b0, 1'b1, 2'd1, 7'd1, 7'd0)
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[s]) begin
      if (script[s].kind == ROW_CFG) begin
        if (!cfg_valid) settle();
        set_reg(script[s].reg_idx, script[s].reg_val);
      end else begin
        cfg_valid <= 1'b0;
        push_word(script[s]);
      end
    end

    // The first random paragraph fills the word limit without a last-word mark.
    while (random_words < RANDOM_WORDS) begin
      random_setup();
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6)) begin
        if (random_words < RANDOM_WORDS) begin
          random_paragraph(random_words == 0);
          if ($urandom_range(0, 7) == 0) settle();
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
